@@ src/tsp_pkg.sv @@
// Shared types and constants for the temperature-to-servo pulse block.
// Used by tsp_div and temperature_to_servo_pulse; no dependencies.
package tsp_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_PERIOD = 2'd1;
  localparam logic [1:0] KIND_WIDTH  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_TEMP_LOW  = 1'b0;
  localparam logic CFG_TEMP_HIGH = 1'b1;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int TEMP_W   = 8;
  localparam int PW_W     = 7;
  localparam int PROD_W   = SAMPLE_W + TEMP_W;  // sample * 250
  localparam int NUM_W    = 14;                 // (temp - low) * 50 < 12500
  localparam int QUO_W    = 6;                  // quotient stays below 50

  // Scaling and width constants
  localparam logic [TEMP_W-1:0] SCALE_MUL       = 8'd250;
  localparam logic [PW_W-1:0]   WIDTH_AT_LOW    = 7'd48;
  localparam logic [PW_W-1:0]   WIDTH_AT_HIGH   = 7'd98;
  localparam logic [PW_W-1:0]   WIDTH_RESET     = 7'd47;
  localparam logic [NUM_W-1:0]  WIDTH_SPAN      = 14'd50;
  localparam logic [TEMP_W-1:0] TEMP_HIGH_RESET = 8'd100;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [TEMP_W-1:0] den;
  } tsp_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } tsp_div_rsp_t;

endpackage

@@ src/tsp_div.sv @@
// Iterative shift-and-subtract divider for the pulse width fraction.
// Depends on tsp_pkg. One quotient bit per cycle, QUO_W quotient bits per division.
module tsp_div
  import tsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  tsp_div_req_t req,
  output tsp_div_rsp_t rsp
);

  localparam int DSH_W  = TEMP_W + QUO_W - 1;
  localparam int STEP_W = $clog2(QUO_W);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [NUM_W-1:0]          rem;
  logic [DSH_W-1:0]          dsh;
  logic [QUO_W-2:0]          quo;
  logic                      ge;
  logic [NUM_W-1:0]          dsh_ext;

  // Trial subtract against the shifted divisor
  assign dsh_ext = NUM_W'(dsh);
  assign ge      = (rem >= dsh_ext);

  assign rsp.done     = busy && (step == '0);
  assign rsp.quotient = {quo, ge};

  // Control: busy flag and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= STEP_W'(QUO_W - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  // Datapath: remainder, shifted divisor, quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh_ext;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QUO_W-3:0], ge};
    end
  end

endmodule

@@ src/temperature_to_servo_pulse.sv @@
// Temperature-to-servo pulse controller top level.
// Depends on tsp_pkg and tsp_div.
//
// Each input transaction yields exactly one result transaction carrying the
// pin level, last temperature and target width after that item. Period and
// width ticks (and the unused kind) produce their result in the cycle after
// acceptance. A converter sample is scaled by one 10x8 multiply, compared
// against temp_low/temp_high, and, when it lies strictly between them, the
// width fraction goes through a shift-and-subtract divider; a sample result
// is registered after the scale and setup states at a bound or outside the
// range, and after the scale, setup and divide states inside the range. The
// block handles one transaction at a time and accepts the next one once the
// previous result is taken (or in the same cycle it is taken). Configuration
// writes take effect at once and should only be issued while the block is
// idle.
module temperature_to_servo_pulse
  import tsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [SAMPLE_W-1:0] sample,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pin_level,
  output logic [TEMP_W-1:0]   temperature,
  output logic [PW_W-1:0]     pulse_width,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [TEMP_W-1:0]   cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCALE = 2'd1;
  localparam logic [1:0] S_SETUP = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]          state;
  logic                pulse_active;
  logic [PW_W-1:0]     ticks_left;
  logic [PW_W-1:0]     target_width;
  logic [TEMP_W-1:0]   last_temperature;
  logic [TEMP_W-1:0]   temp_low;
  logic [TEMP_W-1:0]   temp_high;
  logic [SAMPLE_W-1:0] sample_r;

  logic                in_fire;
  logic                result_done;
  logic [PROD_W-1:0]   scale_prod;
  logic [PW_W-1:0]     ticks_dec;
  logic                at_low;
  logic                at_high;
  logic                between;
  logic [TEMP_W-1:0]   diff;
  tsp_div_req_t        div_req;
  tsp_div_rsp_t        div_rsp;

  // Handshake
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  assign pin_level   = pulse_active;
  assign temperature = last_temperature;
  assign pulse_width = target_width;

  // Scaling and range checks
  assign scale_prod = PROD_W'(sample_r) * PROD_W'(SCALE_MUL);
  assign ticks_dec  = ticks_left - 1'b1;
  assign at_low     = (last_temperature == temp_low);
  assign at_high    = (last_temperature == temp_high);
  assign between    = (last_temperature > temp_low) && (last_temperature < temp_high);
  assign diff       = last_temperature - temp_low;

  // Divider request, issued from the setup state
  assign div_req.start = (state == S_SETUP) && !at_high && !at_low && between;
  assign div_req.num   = NUM_W'(diff) * WIDTH_SPAN;
  assign div_req.den   = temp_high - temp_low;

  // Result ready: ticks at once, samples after setup or after the divide
  assign result_done = (in_fire && (kind != KIND_SAMPLE))
                    || ((state == S_SETUP) && !div_req.start)
                    || ((state == S_DIV) && div_rsp.done);

  tsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sample holding register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= sample;
    end
  end

  // Sequencer, pulse state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      pulse_active     <= 1'b1;
      ticks_left       <= WIDTH_RESET;
      target_width     <= WIDTH_RESET;
      last_temperature <= '0;
      temp_low         <= '0;
      temp_high        <= TEMP_HIGH_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TEMP_LOW:  temp_low  <= cfg_data;
          CFG_TEMP_HIGH: temp_high <= cfg_data;
        endcase
      end

      if (result_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (kind)
              KIND_SAMPLE: begin
                state <= S_SCALE;
              end
              KIND_PERIOD: begin
                pulse_active <= 1'b1;
              end
              KIND_WIDTH: begin
                if (pulse_active) begin
                  if (ticks_dec == '0) begin
                    pulse_active <= 1'b0;
                    ticks_left   <= target_width;
                  end else begin
                    ticks_left <= ticks_dec;
                  end
                end
              end
              KIND_UNUSED: ;
            endcase
          end
        end
        S_SCALE: begin
          last_temperature <= scale_prod[PROD_W-1 -: TEMP_W];
          state            <= S_SETUP;
        end
        S_SETUP: begin
          // the high bound wins over the low bound when they are equal
          priority if (at_high) begin
            target_width <= WIDTH_AT_HIGH;
            state        <= S_IDLE;
          end else if (at_low) begin
            target_width <= WIDTH_AT_LOW;
            state        <= S_IDLE;
          end else if (between) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            target_width <= WIDTH_AT_LOW + PW_W'(div_rsp.quotient);
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new transaction never overwrites a result that is still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (!out_valid || out_ready))
    else $error("input accepted while result pending");

  // Divider completes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // Divider is started only from setup, and the sequencer then waits for it
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> (state == S_DIV))
    else $error("divide state not entered after start");

  // Target width stays in its legal span
  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (target_width >= WIDTH_RESET) && (target_width <= WIDTH_AT_HIGH))
    else $error("target width out of range");

  // A sample never yields a result before scaling has finished
  a_sample_latency: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (kind == KIND_SAMPLE)) |=> !out_valid)
    else $error("sample result issued too early");
`endif

endmodule
